// ===== src/tsxf_pkg.sv =====
package tsxf_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int SLOT_W     = 2;
    localparam int LEN_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LEN_W-1:0]  t_len;

    localparam logic [1:0] FUNC_PUBLISH = 2'd0;
    localparam logic [1:0] FUNC_BEGIN   = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;

    localparam logic       REG_XFADE_LEN = 1'b0;
    localparam t_len       LEN_RESET     = 16'd256;

    typedef struct packed {
        logic apply;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_busy;
    } t_sts;

endpackage

// ===== src/triple_slot_exchange_crossfade.sv =====
// Each input word is taken in S_IDLE, then passes S_PREP, S_DIV (during a crossfade only)
// and S_PUT to its result word; S_PUT waits while a held result still blocks the output.
// During a crossfade the serial gain divider resolves one quotient bit per cycle. The input
// stalls from accept until the result is loaded, so no new word is taken before then.
// The next input word is taken while the previous result waits in the output register.
// Reset (synchronous, active low): all slots 0, nothing pending or fading, length 256.
module triple_slot_exchange_crossfade #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tsxf_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [tsxf_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [tsxf_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_func,
    input  logic                                  i_bank_ok,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_accepted,
    output logic [1:0]                            o_write_slot,
    output logic [1:0]                            o_current_slot,
    output logic                                  o_previous_active,
    output logic [1:0]                            o_previous_slot,
    output logic                                  o_pending_flag,
    output logic [GAIN_FRAC_BITS:0]               o_current_gain,
    output logic [GAIN_FRAC_BITS:0]               o_previous_gain
);
    import tsxf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    tsxf_ctrl #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsxf_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_func),
        .i_bank_ok         (i_bank_ok),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (paddr[CFG_ADDR_W-1]),
        .i_cfg_wdata       (pwdata),
        .o_cfg_rdata       (prdata),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_accepted        (o_accepted),
        .o_write_slot      (o_write_slot),
        .o_current_slot    (o_current_slot),
        .o_previous_active (o_previous_active),
        .o_previous_slot   (o_previous_slot),
        .o_pending_flag    (o_pending_flag),
        .o_current_gain    (o_current_gain),
        .o_previous_gain   (o_previous_gain)
    );

endmodule

// ===== src/tsxf_ctrl.sv =====
module tsxf_ctrl #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tsxf_pkg::t_sts i_sts,
    output tsxf_pkg::t_cmd o_cmd
);
    import tsxf_pkg::*;

    localparam int QW = GAIN_FRAC_BITS + 1;
    localparam int CW = $clog2(QW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_PUT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = i_sts.need_div ? S_DIV : S_PUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/tsxf_dp.sv =====
module tsxf_dp #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tsxf_pkg::t_cmd                        i_cmd,
    output tsxf_pkg::t_sts                        o_sts,
    input  logic [1:0]                            i_func,
    input  logic                                  i_bank_ok,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [tsxf_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output logic [tsxf_pkg::CFG_DATA_W-1:0]       o_cfg_rdata,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic                                  o_accepted,
    output tsxf_pkg::t_slot                       o_write_slot,
    output tsxf_pkg::t_slot                       o_current_slot,
    output logic                                  o_previous_active,
    output tsxf_pkg::t_slot                       o_previous_slot,
    output logic                                  o_pending_flag,
    output logic [GAIN_FRAC_BITS:0]               o_current_gain,
    output logic [GAIN_FRAC_BITS:0]               o_previous_gain
);
    import tsxf_pkg::*;

    localparam int QW = GAIN_FRAC_BITS + 1;
    localparam int NW = LEN_W + QW;
    localparam logic [QW-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

    t_len  r_len;
    t_slot r_cur, r_prev, r_pend;
    logic  r_pv, r_pendv;
    t_len  r_fr;
    logic  r_acc;
    t_slot r_wslot;

    t_slot n_cur, n_prev, n_pend, n_wslot;
    logic  n_pv, n_pendv, n_acc;
    t_len  n_fr;

    logic [SLOT_COUNT-1:0] busy;
    logic                  found;
    t_slot                 free_slot;

    t_len            r_rem;
    logic [QW-1:0]   r_num;
    logic [QW-1:0]   r_quo;
    logic [LEN_W:0]  prog_ext;
    t_len            prog;
    logic [NW-1:0]   num;
    logic [LEN_W:0]  trial;
    logic [LEN_W:0]  diff;
    logic            qbit;
    logic [QW-1:0]   cg;

    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            busy[s] = (t_slot'(s) == r_cur) || (r_pv && t_slot'(s) == r_prev) ||
                      (r_pendv && t_slot'(s) == r_pend);
        end
        found     = 1'b0;
        free_slot = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!busy[s]) begin
                found     = 1'b1;
                free_slot = t_slot'(s);
            end
        end
    end

    always_comb begin
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_pv    = r_pv;
        n_pend  = r_pend;
        n_pendv = r_pendv;
        n_fr    = r_fr;
        n_acc   = 1'b0;
        n_wslot = '0;
        case (i_func)
            FUNC_PUBLISH: begin
                if (i_bank_ok && !r_pendv && found) begin
                    n_pend  = free_slot;
                    n_pendv = 1'b1;
                    n_acc   = 1'b1;
                    n_wslot = free_slot;
                end
            end
            FUNC_BEGIN: begin
                if (r_fr == '0 && r_pendv) begin
                    n_prev  = r_cur;
                    n_pv    = 1'b1;
                    n_cur   = r_pend;
                    n_pendv = 1'b0;
                    n_pend  = '0;
                    n_fr    = r_len;
                end
            end
            FUNC_ADVANCE: begin
                if (r_fr != '0) begin
                    n_fr = r_fr - LEN_W'(1);
                    if (r_fr == LEN_W'(1) && r_pv) begin
                        n_pv   = 1'b0;
                        n_prev = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_RESET;
            r_cur   <= '0;
            r_prev  <= '0;
            r_pv    <= 1'b0;
            r_pend  <= '0;
            r_pendv <= 1'b0;
            r_fr    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_XFADE_LEN) begin
                r_len <= (i_cfg_wdata[LEN_W-1:0] == '0) ? LEN_W'(1) : i_cfg_wdata[LEN_W-1:0];
            end
            if (i_cmd.apply) begin
                r_cur   <= n_cur;
                r_prev  <= n_prev;
                r_pv    <= n_pv;
                r_pend  <= n_pend;
                r_pendv <= n_pendv;
                r_fr    <= n_fr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_acc   <= n_acc;
            r_wslot <= n_wslot;
        end
    end

    assign o_cfg_rdata = (i_cfg_index == REG_XFADE_LEN) ?
                         {{(CFG_DATA_W-LEN_W){1'b0}}, r_len} : '0;

    assign prog_ext = {1'b0, r_len} - {1'b0, r_fr} + (LEN_W+1)'(1);
    assign prog     = (r_fr <= r_len) ? prog_ext[LEN_W-1:0] : '0;
    assign num      = {1'b0, prog, {GAIN_FRAC_BITS{1'b0}}} +
                      {{(QW+1){1'b0}}, r_len[LEN_W-1:1]};
    assign trial    = {r_rem, r_num[QW-1]};
    assign diff     = trial - {1'b0, r_len};
    assign qbit     = (trial >= {1'b0, r_len});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= num[NW-1:QW];
            r_num <= num[QW-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_num <= {r_num[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], qbit};
        end
    end

    assign o_sts.need_div = r_pv && (r_fr != '0);
    assign o_sts.out_busy = o_out_valid && i_out_stall;

    assign cg = o_sts.need_div ? r_quo : GAIN_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_accepted        <= r_acc;
            o_write_slot      <= r_wslot;
            o_current_slot    <= r_cur;
            o_previous_active <= r_pv;
            o_previous_slot   <= r_pv ? r_prev : '0;
            o_pending_flag    <= r_pendv;
            o_current_gain    <= cg;
            o_previous_gain   <= GAIN_ONE - cg;
        end
    end

    a_pend_not_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pendv |-> (r_pend != r_cur))
        else $error("pending slot equals current slot");

    a_prev_not_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_prev != r_cur))
        else $error("previous slot equals current slot");

    a_fade_has_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fr != '0) |-> r_pv)
        else $error("fade running without previous slot");

    a_gain_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_current_gain + o_previous_gain) == GAIN_ONE))
        else $error("gains do not sum to unity");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tsxf_pkg::*;

    localparam int GFB = 16;
    localparam longint unsigned GAIN_ONE = 64'd1 << GFB;
    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int REG_UNMAPPED = 1;
    localparam int SEGMENTS = 6;
    localparam int SEG_WORDS = 100;

    typedef struct packed {
        logic            accepted;
        t_slot           write_slot;
        t_slot           current_slot;
        logic            previous_active;
        t_slot           previous_slot;
        logic            pending_flag;
        logic [GFB:0]    current_gain;
        logic [GFB:0]    previous_gain;
    } t_result;

    class xfade_scoreboard;
        t_slot            cur_slot;
        t_slot            prev_slot;
        t_slot            pend_slot;
        bit               prev_live;
        bit               pend_live;
        bit [LEN_W-1:0]   fade_left;
        int unsigned      fade_len;
        t_result          expected_q[$];
        int unsigned      errors;
        int unsigned      words;
        int unsigned      results;
        int unsigned      taken;
        int unsigned      fades;
        int unsigned      len_writes;

        function new();
            cur_slot = '0;
            prev_slot = '0;
            pend_slot = '0;
            prev_live = 1'b0;
            pend_live = 1'b0;
            fade_left = '0;
            fade_len = LEN_RESET;
        endfunction

        function void set_length(logic [31:0] v);
            fade_len = (v[LEN_W-1:0] == '0) ? 1 : v[LEN_W-1:0];
            len_writes++;
        endfunction

        function bit slot_busy(t_slot s);
            return (s == cur_slot) || (prev_live && s == prev_slot) ||
                   (pend_live && s == pend_slot);
        endfunction

        function void cmp(string fname, logic [31:0] e, logic [31:0] g);
            if (g !== e) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, e, g);
            end
        endfunction

        function void note_word(logic [1:0] f, logic ok);
            t_result r;
            longint unsigned prog;
            longint unsigned g;
            longint unsigned len_l;
            r = '0;
            words++;
            case (f)
                FUNC_PUBLISH: begin
                    if (ok && !pend_live) begin
                        for (int s = 0; s < SLOT_COUNT && !r.accepted; s++) begin
                            if (!slot_busy(t_slot'(s))) begin
                                pend_slot = t_slot'(s);
                                pend_live = 1'b1;
                                r.accepted = 1'b1;
                                r.write_slot = t_slot'(s);
                                taken++;
                            end
                        end
                    end
                end
                FUNC_BEGIN: begin
                    if (fade_left == '0 && pend_live) begin
                        prev_slot = cur_slot;
                        prev_live = 1'b1;
                        cur_slot = pend_slot;
                        pend_live = 1'b0;
                        pend_slot = '0;
                        fade_left = fade_len[LEN_W-1:0];
                        fades++;
                    end
                end
                FUNC_ADVANCE: begin
                    if (fade_left != '0) begin
                        fade_left--;
                        if (fade_left == '0 && prev_live) begin
                            prev_live = 1'b0;
                            prev_slot = '0;
                        end
                    end
                end
                default: ;
            endcase
            r.current_gain = GAIN_ONE[GFB:0];
            r.previous_gain = '0;
            if (prev_live && fade_left != '0) begin
                len_l = fade_len;
                prog = 0;
                if (fade_left <= len_l)
                    prog = len_l - fade_left + 1;
                g = ((prog << GFB) + (len_l >> 1)) / len_l;
                if (g > GAIN_ONE)
                    g = GAIN_ONE;
                r.current_gain = g[GFB:0];
                r.previous_gain = GAIN_ONE[GFB:0] - g[GFB:0];
            end
            r.current_slot = cur_slot;
            r.previous_active = prev_live;
            r.previous_slot = prev_live ? prev_slot : t_slot'(0);
            r.pending_flag = pend_live;
            expected_q.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            results++;
            cmp("accepted", e.accepted, got.accepted);
            cmp("write_slot", e.write_slot, got.write_slot);
            cmp("current_slot", e.current_slot, got.current_slot);
            cmp("previous_active", e.previous_active, got.previous_active);
            cmp("previous_slot", e.previous_slot, got.previous_slot);
            cmp("pending_flag", e.pending_flag, got.pending_flag);
            cmp("current_gain", e.current_gain, got.current_gain);
            cmp("previous_gain", e.previous_gain, got.previous_gain);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_func = FUNC_NOP;
    logic                   i_bank_ok = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_accepted;
    logic [1:0]             o_write_slot;
    logic [1:0]             o_current_slot;
    logic                   o_previous_active;
    logic [1:0]             o_previous_slot;
    logic                   o_pending_flag;
    logic [GFB:0]           o_current_gain;
    logic [GFB:0]           o_previous_gain;

    int gap_pct = 0;
    int stall_pct = 0;
    xfade_scoreboard sb = new();

    triple_slot_exchange_crossfade #(.GAIN_FRAC_BITS(GFB)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_bank_ok(i_bank_ok),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_accepted(o_accepted),
        .o_write_slot(o_write_slot),
        .o_current_slot(o_current_slot),
        .o_previous_active(o_previous_active),
        .o_previous_slot(o_previous_slot),
        .o_pending_flag(o_pending_flag),
        .o_current_gain(o_current_gain),
        .o_previous_gain(o_previous_gain)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word(t_result'{o_accepted, o_write_slot, o_current_slot,
                                    o_previous_active, o_previous_slot, o_pending_flag,
                                    o_current_gain, o_previous_gain});
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic apb_access(bit wr, int idx, logic [31:0] data, output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= CFG_ADDR_W'(4 * idx);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_back_length();
        logic [31:0] rd;
        apb_access(1'b0, REG_XFADE_LEN, '0, rd);
        sb.cmp("crossfade_length readback", sb.fade_len, rd);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (GFB + 4) @(posedge i_clk);
    endtask

    task automatic set_fade_length(logic [31:0] v);
        logic [31:0] rd;
        drain();
        apb_access(1'b1, REG_XFADE_LEN, v, rd);
        sb.set_length(v);
        read_back_length();
    endtask

    task automatic send_word(logic [1:0] f, logic ok);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_bank_ok <= ok;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(f, ok);
    endtask

    task automatic send_any(logic [1:0] f);
        send_word(f, 1'($urandom_range(1)));
    endtask

    task automatic send_random_word();
        int r;
        r = $urandom_range(99);
        if (r < 42)
            send_any(FUNC_ADVANCE);
        else if (r < 68)
            send_word(FUNC_PUBLISH, $urandom_range(99) < 85);
        else if (r < 92)
            send_any(FUNC_BEGIN);
        else
            send_any(FUNC_NOP);
    endtask

    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'd1;
        if (r == 1)
            return 32'd2;
        if (r < 6)
            return $urandom_range(12, 1);
        return $urandom_range(40, 3);
    endfunction

    initial begin
        logic [31:0] rd;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_back_length();
        set_fade_length(32'd0);
        send_any(FUNC_NOP);
        send_any(FUNC_ADVANCE);
        send_any(FUNC_BEGIN);
        send_word(FUNC_PUBLISH, 1'b0);
        send_word(FUNC_PUBLISH, 1'b1);
        send_word(FUNC_PUBLISH, 1'b1);
        send_any(FUNC_BEGIN);
        send_word(FUNC_PUBLISH, 1'b1);
        send_any(FUNC_BEGIN);
        send_any(FUNC_ADVANCE);
        send_word(FUNC_PUBLISH, 1'b1);
        send_any(FUNC_BEGIN);
        send_any(FUNC_ADVANCE);

        set_fade_length(32'hABCD_0004);
        send_word(FUNC_PUBLISH, 1'b1);
        send_any(FUNC_BEGIN);
        set_fade_length(32'h0000_FFFF);
        send_any(FUNC_ADVANCE);
        drain();
        apb_access(1'b1, REG_UNMAPPED, 32'h0000_0005, rd);
        read_back_length();
        set_fade_length(32'd2);
        send_any(FUNC_NOP);
        send_any(FUNC_ADVANCE);
        send_any(FUNC_ADVANCE);
        send_any(FUNC_ADVANCE);

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                set_fade_length(pick_length());
                if (phase == 2) begin
                    gap_pct = 0;
                    stall_pct = 0;
                end else begin
                    gap_pct = (phase == 0) ? 13 : 46;
                    stall_pct = (phase == 0) ? 46 : 13;
                end
                for (int n = 0; n < SEG_WORDS; n++)
                    send_random_word();
            end
        end
        drain();

        $display("%0d words sent, %0d results checked, %0d length settings",
                 sb.words, sb.results, sb.len_writes);
        $display("%0d publishes taken, %0d crossfades started", sb.taken, sb.fades);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("triple_slot_exchange_crossfade regression: pass");
        end else begin
            $display("triple_slot_exchange_crossfade regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("triple_slot_exchange_crossfade regression: fail");
        $finish;
    end

endmodule
